/* design/rrs_pkg.sv */
`default_nettype none
package rrs_pkg;

   localparam int MAX_JOB_SLOTS_DEF = 64;
   localparam int MAX_CPU_DEF       = 4;

   localparam int KIND_W   = 3;
   localparam int JOB_W    = 6;
   localparam int SLOT_W   = 2;
   localparam int CNT_W    = 16;
   localparam int SLICE_W  = 32;
   localparam int MASK_W   = 4;
   localparam int NCPU_W   = 3;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [SLICE_W-1:0] TURN_LIMIT = 32'd60000;
   localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hFFFF;

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ACCEPT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TICK_END = 3'd4;

   // register index 0 (num_cpu) is selected by paddr[2] == 0
   localparam logic REG_NUM_CPU = 1'b0;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SUB    = 10'b0000000010,
      ST_RUN_RD = 10'b0000000100,
      ST_RUN_WR = 10'b0000001000,
      ST_DSP_RD = 10'b0000010000,
      ST_DSP_WR = 10'b0000100000,
      ST_AGE_Q  = 10'b0001000000,
      ST_AGE_W  = 10'b0010000000,
      ST_AGE_U  = 10'b0100000000,
      ST_END    = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

endpackage
`default_nettype wire

/* design/rrs_if.sv */
`default_nettype none
interface rrs_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [rrs_pkg::MASK_W-1:0]   done_mask;

   modport source (output valid, opcode, done_mask, input ready);
   modport sink   (input valid, opcode, done_mask, output ready);
endinterface

interface rrs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rrs_pkg::KIND_W-1:0]   kind;
   logic [rrs_pkg::JOB_W-1:0]    job;
   logic [rrs_pkg::SLOT_W-1:0]   slot;
   logic [rrs_pkg::CNT_W-1:0]    turnaround;
   logic [rrs_pkg::CNT_W-1:0]    waited;
   logic [rrs_pkg::SLICE_W-1:0]  slice_now;
   logic                         last;

   modport source (output valid, kind, job, slot, turnaround, waited, slice_now, last,
                   input ready);
   modport sink   (input valid, kind, job, slot, turnaround, waited, slice_now, last,
                   output ready);
endinterface
`default_nettype wire

/* design/multi_cpu_round_robin_scheduler.sv */
`default_nettype none
// Round-robin job scheduler for up to MAX_CPU processors.
// req channel: one word per submit (opcode 0) or tick (opcode 1, done_mask).
// rsp channel: result words; the last word of each request has last set.
// A submit's word (accepted or rejected) is registered from the submit state once the output is free.
// A tick retires/requeues each running slot (table read, then write), dispatches
// each job (queue read, then slot load), then ages every queued job (queue read,
// wait-table read, wait-table write) before the tick-end word is registered.
// An idle tick gives no word.
// Throughput is one request at a time; req ready is high only between requests.
// The running slots are a row of cells that shift toward slot 0 as they retire.
// The job tables and the ready queue are single-port-write memories with
// registered reads; they need no clearing pass after reset.
// Reset empties queue and slots, clears the slice counter and sets num_cpu to 1.
// When the receiver stalls, the sequencer holds at its next output word until the
// earlier word is taken; a new request may be accepted while the final word still waits.
// CSR: one register num_cpu at address 0 (any address with paddr[2] low), taking effect at the next dispatch.
module multi_cpu_round_robin_scheduler #(
   parameter int MAX_JOB_SLOTS = rrs_pkg::MAX_JOB_SLOTS_DEF,
   parameter int MAX_CPU       = rrs_pkg::MAX_CPU_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   rrs_req_if.sink                         req_port,
   rrs_rsp_if.source                       rsp_port,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [rrs_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [rrs_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [rrs_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready
);
   localparam int JW  = $clog2(MAX_JOB_SLOTS);
   localparam int QCW = $clog2(MAX_JOB_SLOTS + 1);
   localparam int CW  = $clog2(MAX_CPU + 1);
   localparam int SW  = (MAX_CPU > 1) ? $clog2(MAX_CPU) : 1;
   localparam logic [JW-1:0]  LAST_IDX = JW'(MAX_JOB_SLOTS - 1);
   localparam logic [QCW-1:0] FULL_CNT = QCW'(MAX_JOB_SLOTS);
   localparam logic [CW-1:0]  CPU_TOP  = CW'(MAX_CPU);

   typedef logic [rrs_pkg::CNT_W-1:0]   cnt_type;
   typedef logic [rrs_pkg::SLICE_W-1:0] slice_type;

   // ---------------- CSR ----------------
   logic [rrs_pkg::NCPU_W-1:0] ncpu_ff, ncpu_in;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == rrs_pkg::REG_NUM_CPU);

   always_comb begin
      ncpu_in = ncpu_ff;
      if (csr_wr) begin
         ncpu_in = csr_pwdata[rrs_pkg::NCPU_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == rrs_pkg::REG_NUM_CPU) begin
         csr_prdata = rrs_pkg::CSR_DW'(ncpu_ff);
      end
   end

   logic [CW-1:0] cpus;
   always_comb begin
      if (ncpu_ff == '0) begin
         cpus = CW'(1);
      end else if (int'(ncpu_ff) > MAX_CPU) begin
         cpus = CPU_TOP;
      end else begin
         cpus = CW'(ncpu_ff);
      end
   end

   // ---------------- control state ----------------
   rrs_pkg::state_type state_ff, state_in;
   logic [JW-1:0]     head_ff, head_in, tail_ff, tail_in, age_ptr_ff, age_ptr_in;
   logic [QCW-1:0]    qcnt_ff, qcnt_in, age_cnt_ff, age_cnt_in, ja_ff, ja_in;
   logic [CW-1:0]     rc_ff, rc_in, was_ff, was_in, idx_ff, idx_in;
   slice_type         slice_ff, slice_in;
   logic [rrs_pkg::MASK_W-1:0] mask_ff, mask_in;
   logic [rrs_pkg::KIND_W-1:0] sub_kind_ff, sub_kind_in;
   logic [JW-1:0]     sub_job_ff, sub_job_in;

   // ---------------- memories ----------------
   logic [JW-1:0] queue_mem [MAX_JOB_SLOTS];
   slice_type     sub_mem   [MAX_JOB_SLOTS];
   cnt_type       run_mem   [MAX_JOB_SLOTS];
   cnt_type       wait_mem  [MAX_JOB_SLOTS];

   logic          q_re, q_we, j_re, run_we, sub_we, w_re, w_we;
   logic [JW-1:0] q_ra, q_wa, q_wd, q_rd_ff, j_ra, run_wa, w_ra, w_wa;
   slice_type     sub_rd_ff;
   cnt_type       run_rd_ff, wait_rd_ff, run_wd, w_wd;

   always_ff @(posedge clock) begin
      if (q_re) begin
         q_rd_ff <= queue_mem[q_ra];
      end
      if (q_we) begin
         queue_mem[q_wa] <= q_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (j_re) begin
         sub_rd_ff <= sub_mem[j_ra];
      end
      if (sub_we) begin
         sub_mem[JW'(ja_ff)] <= slice_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (j_re) begin
         run_rd_ff <= run_mem[j_ra];
      end
      if (run_we) begin
         run_mem[run_wa] <= run_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (w_re) begin
         wait_rd_ff <= wait_mem[w_ra];
      end
      if (w_we) begin
         wait_mem[w_wa] <= w_wd;
      end
   end

   // ---------------- running slot cells ----------------
   logic [JW-1:0] cell_job [MAX_CPU];
   logic          cell_shift, cell_load;

   for (genvar k = 0; k < MAX_CPU; k++) begin : g_cell
      rrs_pkg::cell_ctl_type ctl;
      logic [JW-1:0]         nxt;
      assign ctl.shift = cell_shift;
      assign ctl.load  = cell_load && (rc_ff == CW'(k));
      if (k == MAX_CPU - 1) begin : g_end
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cell_job[k+1];
      end
      rrs_cell #(.JOB_IW(JW)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_job (q_rd_ff),
         .next_job (nxt),
         .job      (cell_job[k])
      );
   end

   // ---------------- output register ----------------
   logic rsp_valid_ff, out_free, emit;
   logic [rrs_pkg::KIND_W-1:0]  e_kind, kind_ff;
   logic [JW-1:0]               e_job, job_ff;
   logic [SW-1:0]               e_slot, slot_ff;
   cnt_type                     e_turn, e_wait, turn_ff, wait_ff;
   logic                        e_last, last_ff;

   assign out_free = !rsp_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   slice_type slice_out_ff;
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff      <= e_kind;
         job_ff       <= e_job;
         slot_ff      <= e_slot;
         turn_ff      <= e_turn;
         wait_ff      <= e_wait;
         last_ff      <= e_last;
         slice_out_ff <= slice_ff;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.kind       = kind_ff;
   assign rsp_port.job        = rrs_pkg::JOB_W'(job_ff);
   assign rsp_port.slot       = rrs_pkg::SLOT_W'(slot_ff);
   assign rsp_port.turnaround = turn_ff;
   assign rsp_port.waited     = wait_ff;
   assign rsp_port.slice_now  = slice_out_ff;
   assign rsp_port.last       = last_ff;

   // ---------------- sequencer ----------------
   logic          req_acc, fin;
   logic [rrs_pkg::MASK_W-1:0] mask_sh;
   cnt_type       new_run;
   slice_type     diff;

   assign req_port.ready = (state_ff == rrs_pkg::ST_IDLE);
   assign req_acc = req_port.valid && req_port.ready;
   assign mask_sh = mask_ff >> idx_ff;
   assign fin     = mask_sh[0];
   assign new_run = rrs_pkg::sat_inc(run_rd_ff);
   assign diff    = slice_ff - sub_rd_ff;

   function automatic logic [JW-1:0] wrap_inc(input logic [JW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      qcnt_in     = qcnt_ff;
      ja_in       = ja_ff;
      rc_in       = rc_ff;
      was_in      = was_ff;
      idx_in      = idx_ff;
      slice_in    = slice_ff;
      mask_in     = mask_ff;
      age_ptr_in  = age_ptr_ff;
      age_cnt_in  = age_cnt_ff;
      sub_kind_in = sub_kind_ff;
      sub_job_in  = sub_job_ff;

      q_re = 1'b0; q_ra = head_ff;
      q_we = 1'b0; q_wa = tail_ff; q_wd = cell_job[0];
      j_re = 1'b0; j_ra = cell_job[0];
      sub_we = 1'b0;
      run_we = 1'b0; run_wa = cell_job[0]; run_wd = new_run;
      w_re = 1'b0; w_ra = cell_job[0];
      w_we = 1'b0; w_wa = q_rd_ff; w_wd = rrs_pkg::sat_inc(wait_rd_ff);
      cell_shift = 1'b0;
      cell_load  = 1'b0;

      emit   = 1'b0;
      e_kind = rrs_pkg::KIND_TICK_END;
      e_job  = '0;
      e_slot = '0;
      e_turn = '0;
      e_wait = '0;
      e_last = 1'b0;

      case (state_ff)
         rrs_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_port.opcode == rrs_pkg::OP_SUBMIT) begin
                  state_in = rrs_pkg::ST_SUB;
                  if (ja_ff >= FULL_CNT) begin
                     sub_kind_in = rrs_pkg::KIND_REJECT;
                     sub_job_in  = '0;
                  end else begin
                     sub_kind_in = rrs_pkg::KIND_ACCEPT;
                     sub_job_in  = JW'(ja_ff);
                     sub_we = 1'b1;
                     run_we = 1'b1; run_wa = JW'(ja_ff); run_wd = '0;
                     w_we   = 1'b1; w_wa   = JW'(ja_ff); w_wd   = '0;
                     q_we   = 1'b1; q_wd   = JW'(ja_ff);
                     tail_in = wrap_inc(tail_ff);
                     qcnt_in = qcnt_ff + 1'b1;
                     ja_in   = ja_ff + 1'b1;
                  end
               end else if (rc_ff != '0 || qcnt_ff != '0) begin
                  slice_in = slice_ff + 1'b1;
                  mask_in  = req_port.done_mask;
                  was_in   = rc_ff;
                  rc_in    = '0;
                  idx_in   = '0;
                  state_in = rrs_pkg::ST_RUN_RD;
               end
            end
         end
         rrs_pkg::ST_SUB: begin
            if (out_free) begin
               emit   = 1'b1;
               e_kind = sub_kind_ff;
               e_job  = sub_job_ff;
               e_last = 1'b1;
               state_in = rrs_pkg::ST_IDLE;
            end
         end
         rrs_pkg::ST_RUN_RD: begin
            if (idx_ff == was_ff) begin
               state_in = rrs_pkg::ST_DSP_RD;
            end else begin
               j_re = 1'b1;
               w_re = 1'b1;
               state_in = rrs_pkg::ST_RUN_WR;
            end
         end
         rrs_pkg::ST_RUN_WR: begin
            if (!fin || out_free) begin
               run_we = 1'b1;
               if (fin) begin
                  emit   = 1'b1;
                  e_kind = rrs_pkg::KIND_FINISH;
                  e_job  = cell_job[0];
                  e_slot = SW'(idx_ff);
                  e_turn = (diff > rrs_pkg::TURN_LIMIT) ? new_run
                                                        : diff[rrs_pkg::CNT_W-1:0];
                  e_wait = wait_rd_ff;
               end else begin
                  q_we    = 1'b1;
                  tail_in = wrap_inc(tail_ff);
                  qcnt_in = qcnt_ff + 1'b1;
               end
               cell_shift = 1'b1;
               idx_in     = idx_ff + 1'b1;
               state_in   = rrs_pkg::ST_RUN_RD;
            end
         end
         rrs_pkg::ST_DSP_RD: begin
            if (rc_ff < cpus && qcnt_ff != '0) begin
               q_re = 1'b1;
               state_in = rrs_pkg::ST_DSP_WR;
            end else begin
               age_ptr_in = head_ff;
               age_cnt_in = qcnt_ff;
               state_in   = rrs_pkg::ST_AGE_Q;
            end
         end
         rrs_pkg::ST_DSP_WR: begin
            if (out_free) begin
               cell_load = 1'b1;
               emit   = 1'b1;
               e_kind = rrs_pkg::KIND_DISPATCH;
               e_job  = q_rd_ff;
               e_slot = SW'(rc_ff);
               head_in = wrap_inc(head_ff);
               qcnt_in = qcnt_ff - 1'b1;
               rc_in   = rc_ff + 1'b1;
               state_in = rrs_pkg::ST_DSP_RD;
            end
         end
         rrs_pkg::ST_AGE_Q: begin
            if (age_cnt_ff == '0) begin
               state_in = rrs_pkg::ST_END;
            end else begin
               q_re = 1'b1;
               q_ra = age_ptr_ff;
               state_in = rrs_pkg::ST_AGE_W;
            end
         end
         rrs_pkg::ST_AGE_W: begin
            w_re = 1'b1;
            w_ra = q_rd_ff;
            state_in = rrs_pkg::ST_AGE_U;
         end
         rrs_pkg::ST_AGE_U: begin
            w_we = 1'b1;
            age_ptr_in = wrap_inc(age_ptr_ff);
            age_cnt_in = age_cnt_ff - 1'b1;
            state_in   = rrs_pkg::ST_AGE_Q;
         end
         rrs_pkg::ST_END: begin
            if (out_free) begin
               emit   = 1'b1;
               e_kind = rrs_pkg::KIND_TICK_END;
               e_last = 1'b1;
               state_in = rrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rrs_pkg::ST_IDLE;
         ncpu_ff    <= rrs_pkg::NCPU_W'(1);
         head_ff    <= '0;
         tail_ff    <= '0;
         qcnt_ff    <= '0;
         ja_ff      <= '0;
         rc_ff      <= '0;
         was_ff     <= '0;
         idx_ff     <= '0;
         slice_ff   <= '0;
         age_ptr_ff <= '0;
         age_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ncpu_ff    <= ncpu_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         qcnt_ff    <= qcnt_in;
         ja_ff      <= ja_in;
         rc_ff      <= rc_in;
         was_ff     <= was_in;
         idx_ff     <= idx_in;
         slice_ff   <= slice_in;
         age_ptr_ff <= age_ptr_in;
         age_cnt_ff <= age_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      sub_kind_ff <= sub_kind_in;
      sub_job_ff  <= sub_job_in;
   end
endmodule
`default_nettype wire

/* design/rrs_cell.sv */
`default_nettype none
// One running slot. Shifts toward slot 0 while the slots are retired in order.
module rrs_cell #(
   parameter int JOB_IW = 6
) (
   input  wire logic                 clock,
   input  wire rrs_pkg::cell_ctl_type ctl,
   input  wire logic [JOB_IW-1:0]    load_job,
   input  wire logic [JOB_IW-1:0]    next_job,
   output logic      [JOB_IW-1:0]    job
);
   logic [JOB_IW-1:0] job_ff;
   logic [JOB_IW-1:0] job_in;

   always_comb begin
      job_in = job_ff;
      if (ctl.load) begin
         job_in = load_job;
      end else if (ctl.shift) begin
         job_in = next_job;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job = job_ff;
endmodule
`default_nettype wire

/* design/rrs_checker.sv */
`default_nettype none
module rrs_props (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [rrs_pkg::KIND_W-1:0]  rsp_kind,
   input wire logic [rrs_pkg::JOB_W-1:0]   rsp_job,
   input wire logic                        rsp_last
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_job))
      else $error("stalled rsp word changed");

   a_submit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rrs_pkg::KIND_ACCEPT || rsp_kind == rrs_pkg::KIND_REJECT
                    || rsp_kind == rrs_pkg::KIND_TICK_END) |-> rsp_last)
      else $error("closing word without last");

   a_mid_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rrs_pkg::KIND_FINISH || rsp_kind == rrs_pkg::KIND_DISPATCH)
      |-> !rsp_last)
      else $error("finish/dispatch word marked last");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= rrs_pkg::KIND_TICK_END)
      else $error("bad rsp kind");
endmodule

bind multi_cpu_round_robin_scheduler rrs_props u_rrs_props (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_kind  (rsp_port.kind),
   .rsp_job   (rsp_port.job),
   .rsp_last  (rsp_port.last)
);
`default_nettype wire

/* bench/rrs_checker.sv */
`default_nettype none
module rrs_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   rrs_req_if                              req_mon,
   rrs_rsp_if                              rsp_mon,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic                       csr_pready,
   input  wire logic [rrs_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [rrs_pkg::CSR_DW-1:0] csr_pwdata,
   output int                              fail_count,
   output int                              pending_words,
   output int                              words_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import rrs_pkg::*;

   localparam int NJOB = MAX_JOB_SLOTS_DEF;
   localparam int NCPU = MAX_CPU_DEF;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [JOB_W-1:0]   job;
      logic [SLOT_W-1:0]  slot;
      logic [CNT_W-1:0]   turnaround;
      logic [CNT_W-1:0]   waited;
      logic [SLICE_W-1:0] slice_now;
      logic               last;
   } sched_word_t;

   sched_word_t        expected_words[$];

   // scheduler shadow state
   logic [NCPU_W-1:0]  cpu_cfg;
   logic [JOB_W-1:0]   ready_ring[NJOB];
   int                 ring_head, ring_tail, ring_fill;
   int                 jobs_taken;
   logic [JOB_W-1:0]   slot_job[NCPU];
   int                 slots_busy;
   logic [SLICE_W-1:0] slice_cnt;
   logic [SLICE_W-1:0] born_slice[NJOB];
   logic [CNT_W-1:0]   ran_slices[NJOB];
   logic [CNT_W-1:0]   waited_slices[NJOB];
   int                 fails, checked;

   function automatic logic [CNT_W-1:0] bump16(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 16'd1;
   endfunction

   task automatic add_word(input logic [KIND_W-1:0] kind, input logic [JOB_W-1:0] job,
                           input logic [SLOT_W-1:0] slot, input logic [CNT_W-1:0] turn,
                           input logic [CNT_W-1:0] wt, input logic last);
      sched_word_t w;
      w = '{kind, job, slot, turn, wt, slice_cnt, last};
      expected_words.push_back(w);
   endtask

   task automatic enqueue_job(input logic [JOB_W-1:0] job);
      if (ring_fill < NJOB) begin
         ready_ring[ring_tail] = job;
         ring_tail = (ring_tail + 1) % NJOB;
         ring_fill++;
      end
   endtask

   task automatic schedule_item(input logic op, input logic [MASK_W-1:0] mask);
      int                 ncpu, was, i;
      logic [JOB_W-1:0]   job;
      logic [SLICE_W-1:0] turn;
      if (op == OP_SUBMIT) begin
         if (jobs_taken >= NJOB) begin
            add_word(KIND_REJECT, '0, '0, '0, '0, 1'b1);
         end else begin
            job = JOB_W'(jobs_taken);
            jobs_taken++;
            born_slice[job] = slice_cnt;
            ran_slices[job] = '0;
            waited_slices[job] = '0;
            enqueue_job(job);
            add_word(KIND_ACCEPT, job, '0, '0, '0, 1'b1);
         end
      end else if (slots_busy != 0 || ring_fill != 0) begin
         slice_cnt = slice_cnt + 1;
         ncpu = (cpu_cfg == 0) ? 1 : (cpu_cfg > NCPU) ? NCPU : int'(cpu_cfg);
         was = slots_busy;
         slots_busy = 0;
         for (i = 0; i < was; i++) begin
            job = slot_job[i];
            ran_slices[job] = bump16(ran_slices[job]);
            if (mask[i]) begin
               turn = slice_cnt - born_slice[job];
               if (turn > TURN_LIMIT) turn = SLICE_W'(ran_slices[job]);
               add_word(KIND_FINISH, job, SLOT_W'(i), turn[CNT_W-1:0],
                        waited_slices[job], 1'b0);
            end else begin
               enqueue_job(job);
            end
         end
         while (slots_busy < ncpu && ring_fill > 0) begin
            job = ready_ring[ring_head];
            ring_head = (ring_head + 1) % NJOB;
            ring_fill--;
            slot_job[slots_busy] = job;
            add_word(KIND_DISPATCH, job, SLOT_W'(slots_busy), '0, '0, 1'b0);
            slots_busy++;
         end
         for (i = 0; i < ring_fill; i++) begin
            job = ready_ring[(ring_head + i) % NJOB];
            waited_slices[job] = bump16(waited_slices[job]);
         end
         add_word(KIND_TICK_END, '0, '0, '0, '0, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      sched_word_t got, want;
      if (reset) begin
         cpu_cfg = NCPU_W'(1);
         ring_head = 0;
         ring_tail = 0;
         ring_fill = 0;
         jobs_taken = 0;
         slots_busy = 0;
         slice_cnt = '0;
         expected_words.delete();
         fails = 0;
         checked = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.kind, rsp_mon.job, rsp_mon.slot, rsp_mon.turnaround,
                    rsp_mon.waited, rsp_mon.slice_now, rsp_mon.last};
            checked++;
            if (expected_words.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected word: kind=%0d job=%0d slot=%0d slice=%0d",
                           got.kind, got.job, got.slot, got.slice_now);
            end else begin
               want = expected_words.pop_front();
               if (got != want) begin
                  fails++;
                  if (fails <= 10)
                     $display({"mismatch: exp kind=%0d job=%0d slot=%0d turn=%0d ",
                               "wait=%0d slice=%0d last=%0d | got kind=%0d job=%0d ",
                               "slot=%0d turn=%0d wait=%0d slice=%0d last=%0d"},
                              want.kind, want.job, want.slot, want.turnaround,
                              want.waited, want.slice_now, want.last,
                              got.kind, got.job, got.slot, got.turnaround,
                              got.waited, got.slice_now, got.last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            schedule_item(req_mon.opcode, req_mon.done_mask);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_NUM_CPU)
            cpu_cfg = csr_pwdata[NCPU_W-1:0];
      end
      fail_count <= fails;
      pending_words <= expected_words.size();
      words_checked <= checked;
   end
endmodule
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rrs_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [CSR_AW-1:0] ADDR_NUM_CPU = {REG_NUM_CPU, 2'b00};

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   logic idle_on;
   int   fail_count, pending_words, words_checked;
   int   items_sent, quiet;

   rrs_req_if req_if();
   rrs_rsp_if rsp_if();

   multi_cpu_round_robin_scheduler u_top (
      .clock(clock), .reset(reset), .req_port(req_if), .rsp_port(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   rrs_checker u_chk (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending_words(pending_words),
      .words_checked(words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_word(input logic op, input logic [MASK_W-1:0] mask);
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.done_mask <= mask;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain_all();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      // a trailing idle tick may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_num_cpu(input logic [NCPU_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_NUM_CPU;
      csr_pwdata <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 6) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      logic [NCPU_W-1:0] phase_cfg[7];
      int p, n;
      phase_cfg = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6, 3'd4};
      items_sent = 0;
      idle_on <= 1'b1;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.opcode <= OP_SUBMIT;
      req_if.done_mask <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset default of one cpu; idle ticks give nothing
      send_word(OP_TICK, 4'h0);
      send_word(OP_TICK, 4'hF);
      repeat (3) send_word(OP_SUBMIT, 4'h0);
      send_word(OP_TICK, 4'h0);
      send_word(OP_TICK, 4'hE);   // bits past the busy slots are ignored
      send_word(OP_TICK, 4'h1);
      drain_all();
      write_num_cpu(3'd4);
      repeat (6) send_word(OP_SUBMIT, 4'hF);
      send_word(OP_TICK, 4'h0);
      send_word(OP_TICK, 4'hA);
      send_word(OP_TICK, 4'h5);
      send_word(OP_TICK, 4'h0);
      send_word(OP_TICK, 4'hF);
      send_word(OP_TICK, 4'hF);
      send_word(OP_TICK, 4'hF);
      drain_all();

      for (p = 0; p < 7; p++) begin
         write_num_cpu(phase_cfg[p]);
         for (n = 0; n < 21; n++) begin
            if (p == 5 && n == 0) idle_on <= 1'b0;
            if (p == 2 && n == 10) drain_all();
            if ($urandom_range(0, 99) < 40)
               send_word(OP_SUBMIT, 4'($urandom));
            else if ($urandom_range(0, 3) == 0)
               send_word(OP_TICK, 4'($urandom));
            else
               send_word(OP_TICK, 4'($urandom_range(0, 15) & $urandom_range(0, 15)));
         end
         drain_all();
      end

      $display("sent %0d items over 9 cpu settings, checked %0d result words",
               items_sent, words_checked);
      $display("covered submit, reject on full table, dispatch, finish and idle ticks");
      if (fail_count == 0 && pending_words == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
